/* rtl/ihrp_pkg.sv */
package ihrp_pkg;

    localparam int REC_LEN_W        = 5;
    localparam int MAX_RECORD_BYTES = 16;
    localparam int RECORD_BYTES_DEF = 16;
    localparam int DATA_W           = 8 * MAX_RECORD_BYTES;

    localparam logic [7:0] REC_TYPE_DATA = 8'h00;

    typedef struct packed {
        logic [15:0]          addr;
        logic [REC_LEN_W-1:0] len;
        logic [DATA_W-1:0]    data;
        logic [7:0]           csum;
        logic                 last;
    } rec_t;

    // Two's complement of the byte sum over length, address, record type and data.
    function automatic logic [7:0] rec_checksum(
        input logic [REC_LEN_W-1:0] len,
        input logic [15:0]          baddr,
        input logic [7:0]           data_sum
    );
        logic [7:0] s;
        s = 8'(len) + baddr[15:8] + baddr[7:0] + REC_TYPE_DATA + data_sum;
        return 8'(8'd0 - s);
    endfunction

endpackage

/* rtl/intel_hex_record_packer_unit.sv */
// An accepted transaction enters the input register; its records then enter the output queue.
// Throughput: one transaction per cycle while each yields at most one record and the output
// queue has room; the result side moves one record per cycle while m_ready is high, so a
// transaction that closes two records is buffered by the two-entry output queue.
// Reset: aresetn is synchronous and active low; it empties the open record, the input
// register and the output queue. The record data bytes themselves are not reset.
module intel_hex_record_packer_unit #(
    parameter int RECORD_BYTES = ihrp_pkg::RECORD_BYTES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [15:0]                    s_word_address,
    input  logic [31:0]                    s_opcode_value,
    input  logic                           s_is_four_byte,
    input  logic                           s_end_of_program,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [15:0]                    m_record_address,
    output logic [ihrp_pkg::REC_LEN_W-1:0] m_record_length,
    output logic [63:0]                    m_bytes_low,
    output logic [63:0]                    m_bytes_high,
    output logic [7:0]                     m_record_checksum,
    output logic                           m_run_last
);

    // Data always arrives in 16-bit words, so an odd size loses its last byte.
    localparam int CAP = (RECORD_BYTES / 2) * 2;
    localparam logic [ihrp_pkg::REC_LEN_W-1:0] CAP_LEN = ihrp_pkg::REC_LEN_W'(CAP);

    typedef logic [CAP-1:0][7:0] rec_bytes_t;

    // Input register
    logic        in_valid_reg;
    logic [15:0] in_addr_reg;
    logic [31:0] in_op_reg;
    logic        in_four_reg;
    logic        in_end_reg;

    // Open record state
    rec_bytes_t                     rec_buf_reg;
    logic [ihrp_pkg::REC_LEN_W-1:0] fill_reg;
    logic [15:0]                    start_reg;
    logic [15:0]                    last_word_reg;
    logic [7:0]                     sum_reg;

    // Output queue: head register and one spare
    ihrp_pkg::rec_t out_reg, out_next;
    ihrp_pkg::rec_t spare_reg, spare_next;
    logic [1:0]     occ_reg, occ_next;

    function automatic ihrp_pkg::rec_t build_record(
        input rec_bytes_t                     bytes,
        input logic [ihrp_pkg::REC_LEN_W-1:0] len,
        input logic [15:0]                    start_word,
        input logic [7:0]                     data_sum
    );
        ihrp_pkg::rec_t r;
        r      = '0;
        r.addr = {start_word[14:0], 1'b0};
        r.len  = len;
        for (int k = 0; k < CAP; k++) begin
            if (ihrp_pkg::REC_LEN_W'(k) < len) begin
                r.data[8*k +: 8] = bytes[k];
            end
        end
        r.csum = ihrp_pkg::rec_checksum(len, r.addr, data_sum);
        return r;
    endfunction

    logic                           gap;
    logic                           split;
    logic                           close_w;
    logic [ihrp_pkg::REC_LEN_W-1:0] f;
    logic [ihrp_pkg::REC_LEN_W-1:0] wfill;
    logic [15:0]                    st;
    logic [15:0]                    wstart;
    logic [15:0]                    addr_inc;
    logic [7:0]                     sum_old;
    logic [7:0]                     hi_sum;
    logic [7:0]                     lo_sum;
    logic [7:0]                     wsum;
    logic [7:0]                     b0, b1, b2, b3;
    rec_bytes_t                     merged;
    rec_bytes_t                     wbuf;
    ihrp_pkg::rec_t                 rec_a, rec_b, rec_w, r0, r1;
    logic [1:0]                     cnt;
    logic                           pop;
    logic [1:0]                     occ_after;
    logic                           consume;

    always_comb begin
        addr_inc = 16'(in_addr_reg + 16'd1);
        gap      = (fill_reg != '0) && (in_addr_reg != 16'(last_word_reg + 16'd1));
        f        = gap ? '0 : fill_reg;
        st       = (f == '0) ? in_addr_reg : start_reg;
        sum_old  = gap ? 8'd0 : sum_reg;
        hi_sum   = 8'(in_op_reg[23:16] + in_op_reg[31:24]);
        lo_sum   = 8'(in_op_reg[7:0] + in_op_reg[15:8]);

        // A four-byte instruction goes high word first; each word low byte first.
        if (in_four_reg) begin
            b0 = in_op_reg[23:16];
            b1 = in_op_reg[31:24];
        end else begin
            b0 = in_op_reg[7:0];
            b1 = in_op_reg[15:8];
        end
        b2 = in_op_reg[7:0];
        b3 = in_op_reg[15:8];

        for (int i = 0; i < CAP; i++) begin
            merged[i] = rec_buf_reg[i];
            if (ihrp_pkg::REC_LEN_W'(i) == f) begin
                merged[i] = b0;
            end
            if (ihrp_pkg::REC_LEN_W'(i) == ihrp_pkg::REC_LEN_W'(f + 5'd1)) begin
                merged[i] = b1;
            end
            if (in_four_reg && ihrp_pkg::REC_LEN_W'(i) == ihrp_pkg::REC_LEN_W'(f + 5'd2)) begin
                merged[i] = b2;
            end
            if (in_four_reg && ihrp_pkg::REC_LEN_W'(i) == ihrp_pkg::REC_LEN_W'(f + 5'd3)) begin
                merged[i] = b3;
            end
        end

        // Only one word left: the high word closes this record, the low word opens the next.
        split = in_four_reg && (ihrp_pkg::REC_LEN_W'(f + 5'd4) > CAP_LEN);

        wbuf = merged;
        if (split) begin
            wbuf[0] = in_op_reg[7:0];
            wbuf[1] = in_op_reg[15:8];
            wfill   = ihrp_pkg::REC_LEN_W'(2);
            wstart  = addr_inc;
            wsum    = lo_sum;
        end else begin
            wfill  = ihrp_pkg::REC_LEN_W'(f + (in_four_reg ? 5'd4 : 5'd2));
            wstart = st;
            wsum   = in_four_reg ? 8'(sum_old + hi_sum + lo_sum) : 8'(sum_old + lo_sum);
        end
        close_w = (wfill == CAP_LEN) || in_end_reg;

        rec_a = build_record(rec_buf_reg, fill_reg, start_reg, sum_reg);
        rec_b = build_record(merged, CAP_LEN, st, 8'(sum_old + hi_sum));
        rec_w = build_record(wbuf, wfill, wstart, wsum);

        cnt = 2'(gap) + 2'(split) + 2'(close_w);

        if (gap) begin
            r0 = rec_a;
        end else if (split) begin
            r0 = rec_b;
        end else begin
            r0 = rec_w;
        end
        r0.last = (cnt == 2'd1);
        r1      = rec_w;
        r1.last = 1'b1;
    end

    // Queue bookkeeping
    always_comb begin
        pop       = (occ_reg != 2'd0) && m_ready;
        occ_after = occ_reg - 2'(pop);
        consume   = in_valid_reg && ((3'(occ_after) + 3'(cnt)) <= 3'd2);
        occ_next  = occ_after + (consume ? cnt : 2'd0);

        out_next   = out_reg;
        spare_next = spare_reg;
        case (occ_after)
            2'd0: begin
                out_next   = r0;
                spare_next = r1;
            end
            2'd1: begin
                if (occ_reg == 2'd2) begin
                    out_next = spare_reg;
                end
                if (consume) begin
                    spare_next = r0;
                end
            end
            default: begin
            end
        endcase
    end

    assign s_ready = !in_valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            fill_reg      <= '0;
            start_reg     <= '0;
            last_word_reg <= '0;
            sum_reg       <= '0;
            occ_reg       <= 2'd0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (consume) begin
                in_valid_reg <= 1'b0;
            end
            if (consume) begin
                fill_reg      <= close_w ? '0 : wfill;
                start_reg     <= wstart;
                last_word_reg <= in_four_reg ? addr_inc : in_addr_reg;
                sum_reg       <= close_w ? 8'd0 : wsum;
            end
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_addr_reg <= s_word_address;
            in_op_reg   <= s_opcode_value;
            in_four_reg <= s_is_four_byte;
            in_end_reg  <= s_end_of_program;
        end
        if (consume) begin
            rec_buf_reg <= wbuf;
        end
        out_reg   <= out_next;
        spare_reg <= spare_next;
    end

    assign m_valid           = (occ_reg != 2'd0);
    assign m_record_address  = out_reg.addr;
    assign m_record_length   = out_reg.len;
    assign m_bytes_low       = out_reg.data[63:0];
    assign m_bytes_high      = out_reg.data[127:64];
    assign m_record_checksum = out_reg.csum;
    assign m_run_last        = out_reg.last;

endmodule

/* rtl/ihrp_checker.sv */
module ihrp_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [15:0]                    m_record_address,
    input logic [ihrp_pkg::REC_LEN_W-1:0] m_record_length,
    input logic [63:0]                    m_bytes_low,
    input logic [63:0]                    m_bytes_high,
    input logic [7:0]                     m_record_checksum,
    input logic                           m_run_last
);

    function automatic logic [7:0] byte_total(
        input logic [15:0]                    addr,
        input logic [ihrp_pkg::REC_LEN_W-1:0] len,
        input logic [127:0]                   data,
        input logic [7:0]                     csum
    );
        logic [7:0] s;
        s = 8'(len) + addr[15:8] + addr[7:0] + ihrp_pkg::REC_TYPE_DATA + csum;
        for (int k = 0; k < ihrp_pkg::MAX_RECORD_BYTES; k++) begin
            s = 8'(s + data[8*k +: 8]);
        end
        return s;
    endfunction

    // A stalled transaction keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_record_address)
            && $stable(m_record_length) && $stable(m_bytes_low)
            && $stable(m_bytes_high) && $stable(m_record_checksum) && $stable(m_run_last))
        else $error("result changed while stalled");

    // Records hold whole words and start on a word boundary.
    a_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_record_length != '0 && !m_record_length[0]
            && m_record_length <= ihrp_pkg::REC_LEN_W'(ihrp_pkg::MAX_RECORD_BYTES)
            && !m_record_address[0])
        else $error("bad record length or address");

    // Bytes past the record length read as zero, checked on the high eight bytes of short records.
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_record_length <= ihrp_pkg::REC_LEN_W'(8) |-> m_bytes_high == 64'd0)
        else $error("unused data bytes not zero");

    // The checksum brings the record byte sum to zero.
    a_csum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> byte_total(m_record_address, m_record_length,
                               {m_bytes_high, m_bytes_low}, m_record_checksum) == 8'd0)
        else $error("record checksum mismatch");

endmodule

bind intel_hex_record_packer_unit ihrp_checker u_ihrp_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_record_address  (m_record_address),
    .m_record_length   (m_record_length),
    .m_bytes_low       (m_bytes_low),
    .m_bytes_high      (m_bytes_high),
    .m_record_checksum (m_record_checksum),
    .m_run_last        (m_run_last)
);

/* sim/ihex_record_checker.sv */
module ihex_record_checker #(
    parameter int RECORD_BYTES = ihrp_pkg::RECORD_BYTES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [15:0]                    s_word_address,
    input  logic [31:0]                    s_opcode_value,
    input  logic                           s_is_four_byte,
    input  logic                           s_end_of_program,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [15:0]                    m_record_address,
    input  logic [ihrp_pkg::REC_LEN_W-1:0] m_record_length,
    input  logic [63:0]                    m_bytes_low,
    input  logic [63:0]                    m_bytes_high,
    input  logic [7:0]                     m_record_checksum,
    input  logic                           m_run_last,
    output int                             error_count,
    output int                             pending_records,
    output int                             records_checked
);

    // Data always arrives in 16-bit words, so an odd size loses its last byte.
    localparam int CAPACITY = RECORD_BYTES & 'h1E;

    logic [7:0]       rec_bytes [0:15];
    int               fill;
    logic [15:0]      rec_start;
    logic [15:0]      prev_word;
    logic [7:0]       data_sum;
    ihrp_pkg::rec_t   item_records[$];
    ihrp_pkg::rec_t   predicted_records[$];

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("ERROR: record %0d %s: got %h, expected %h", records_checked, what, got, want);
        error_count++;
    endtask

    function automatic void append_byte(input logic [7:0] b);
        if (fill < 16) begin
            rec_bytes[fill] = b;
            fill++;
            data_sum = data_sum + b;
        end
    endfunction

    function automatic void append_word(input logic [15:0] w);
        append_byte(w[7:0]);
        append_byte(w[15:8]);
    endfunction

    function automatic void close_record();
        ihrp_pkg::rec_t rec;
        logic [15:0]    byte_addr;
        logic [7:0]     sum;
        byte_addr = {rec_start[14:0], 1'b0};
        rec = '0;
        for (int k = 0; k < fill; k++) begin
            rec.data[8*k +: 8] = rec_bytes[k];
        end
        rec.addr = byte_addr;
        rec.len = ihrp_pkg::REC_LEN_W'(fill);
        sum = 8'(fill) + byte_addr[15:8] + byte_addr[7:0] + ihrp_pkg::REC_TYPE_DATA + data_sum;
        rec.csum = 8'd0 - sum;
        rec.last = 1'b0;
        item_records.push_back(rec);
        fill = 0;
        data_sum = '0;
    endfunction

    function automatic void pack_instruction(input logic [15:0] addr, input logic [31:0] op,
                                             input logic four, input logic eop);
        logic [15:0]    next_word;
        ihrp_pkg::rec_t rec;
        item_records.delete();
        next_word = prev_word + 16'd1;
        if (fill != 0 && addr != next_word) begin
            close_record();
        end
        if (fill == 0) begin
            rec_start = addr;
        end
        if (four) begin
            append_word(op[31:16]);
            // Only two bytes left: the low word goes to a fresh record.
            if (fill + 2 > CAPACITY) begin
                close_record();
                rec_start = addr + 16'd1;
            end
            append_word(op[15:0]);
            prev_word = addr + 16'd1;
        end else begin
            append_word(op[15:0]);
            prev_word = addr;
        end
        if (fill >= CAPACITY) begin
            close_record();
        end
        if (eop && fill != 0) begin
            close_record();
        end
        for (int i = 0; i < item_records.size(); i++) begin
            rec = item_records[i];
            rec.last = (i == item_records.size() - 1);
            predicted_records.push_back(rec);
        end
    endfunction

    always @(posedge aclk) begin
        ihrp_pkg::rec_t want;
        if (!aresetn) begin
            fill = 0;
            rec_start = '0;
            prev_word = '0;
            data_sum = '0;
            predicted_records.delete();
            error_count = 0;
            records_checked = 0;
        end else begin
            if (s_valid && s_ready) begin
                pack_instruction(s_word_address, s_opcode_value, s_is_four_byte,
                                 s_end_of_program);
            end
            if (m_valid && m_ready) begin
                if (predicted_records.size() == 0) begin
                    flag_mismatch("arrived with none outstanding", 64'(m_record_address), '0);
                end else begin
                    want = predicted_records.pop_front();
                    if (m_record_address !== want.addr)
                        flag_mismatch("address", 64'(m_record_address), 64'(want.addr));
                    if (m_record_length !== want.len)
                        flag_mismatch("length", 64'(m_record_length), 64'(want.len));
                    if (m_bytes_low !== want.data[63:0])
                        flag_mismatch("bytes 0..7", m_bytes_low, want.data[63:0]);
                    if (m_bytes_high !== want.data[127:64])
                        flag_mismatch("bytes 8..15", m_bytes_high, want.data[127:64]);
                    if (m_record_checksum !== want.csum)
                        flag_mismatch("checksum", 64'(m_record_checksum), 64'(want.csum));
                    if (m_run_last !== want.last)
                        flag_mismatch("last flag", 64'(m_run_last), 64'(want.last));
                end
                records_checked++;
            end
        end
        pending_records <= predicted_records.size();
    end

endmodule

/* sim/tb.sv */
module tb;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_word_address = '0;
    logic [31:0] s_opcode_value = '0;
    logic        s_is_four_byte = 1'b0;
    logic        s_end_of_program = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_record_address;
    logic [ihrp_pkg::REC_LEN_W-1:0] m_record_length;
    logic [63:0] m_bytes_low;
    logic [63:0] m_bytes_high;
    logic [7:0]  m_record_checksum;
    logic        m_run_last;

    int          error_count;
    int          pending_records;
    int          records_checked;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          items_sent = 0;
    int          directed_items = 0;
    logic [15:0] last_sent_addr = '0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    intel_hex_record_packer_unit u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_word_address    (s_word_address),
        .s_opcode_value    (s_opcode_value),
        .s_is_four_byte    (s_is_four_byte),
        .s_end_of_program  (s_end_of_program),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_record_address  (m_record_address),
        .m_record_length   (m_record_length),
        .m_bytes_low       (m_bytes_low),
        .m_bytes_high      (m_bytes_high),
        .m_record_checksum (m_record_checksum),
        .m_run_last        (m_run_last)
    );

    ihex_record_checker u_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_word_address    (s_word_address),
        .s_opcode_value    (s_opcode_value),
        .s_is_four_byte    (s_is_four_byte),
        .s_end_of_program  (s_end_of_program),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_record_address  (m_record_address),
        .m_record_length   (m_record_length),
        .m_bytes_low       (m_bytes_low),
        .m_bytes_high      (m_bytes_high),
        .m_record_checksum (m_record_checksum),
        .m_run_last        (m_run_last),
        .error_count       (error_count),
        .pending_records   (pending_records),
        .records_checked   (records_checked)
    );

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Returns at the edge where the transaction was accepted.
    task automatic send_instr(input logic [15:0] addr, input logic [31:0] op,
                              input logic four, input logic eop);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word_address <= addr;
        s_opcode_value <= op;
        s_is_four_byte <= four;
        s_end_of_program <= eop;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        last_sent_addr = addr;
        items_sent++;
    endtask

    // The outstanding count is registered, so look only after the next edge.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_records != 0) @(posedge aclk);
    endtask

    task automatic run_directed();
        // Filling up, then a 4-byte instruction split over two records.
        send_instr(16'h0000, 32'hFFFF_1234, 1'b0, 1'b0);
        send_instr(16'h0001, 32'hFFFF_FFFF, 1'b1, 1'b0);
        send_instr(16'h0003, 32'h0000_0000, 1'b1, 1'b0);
        send_instr(16'h0005, 32'h8001_7FFE, 1'b1, 1'b0);
        send_instr(16'h0007, 32'hA5A5_5A5A, 1'b1, 1'b0);
        // Repeated address, lower address and a gap each close the record.
        send_instr(16'h0009, 32'h0000_C3C3, 1'b0, 1'b0);
        send_instr(16'h0009, 32'h0000_1111, 1'b0, 1'b0);
        send_instr(16'h0004, 32'h0000_2222, 1'b0, 1'b0);
        send_instr(16'h1000, 32'h1234_5678, 1'b1, 1'b0);
        send_instr(16'h1002, 32'h0000_9ABC, 1'b0, 1'b1);
        send_instr(16'h2000, 32'hDEAD_BEEF, 1'b1, 1'b1);
        // Exactly full on end of program: the end flag finds nothing left.
        send_instr(16'h3000, 32'h0102_0304, 1'b1, 1'b0);
        send_instr(16'h3002, 32'h0506_0708, 1'b1, 1'b0);
        send_instr(16'h3004, 32'h090A_0B0C, 1'b1, 1'b0);
        send_instr(16'h3006, 32'h0D0E_0F10, 1'b1, 1'b1);
        // Split together with end of program gives two records.
        send_instr(16'h4000, 32'h1111_2222, 1'b1, 1'b0);
        send_instr(16'h4002, 32'h3333_4444, 1'b1, 1'b0);
        send_instr(16'h4004, 32'h5555_6666, 1'b1, 1'b0);
        send_instr(16'h4006, 32'h0000_7777, 1'b0, 1'b0);
        send_instr(16'h4007, 32'h8888_9999, 1'b1, 1'b1);
        // A gap with end of program closes the old and the new record.
        send_instr(16'h5000, 32'h0000_AAAA, 1'b0, 1'b0);
        send_instr(16'h6000, 32'h0000_BBBB, 1'b0, 1'b1);
        // Word and byte addresses wrapping at 16 bits.
        send_instr(16'hFFFF, 32'hCAFE_F00D, 1'b1, 1'b0);
        send_instr(16'h0001, 32'h7654_3210, 1'b1, 1'b0);
        send_instr(16'h0003, 32'hFEDC_BA98, 1'b1, 1'b0);
        send_instr(16'h0005, 32'h0000_5A5A, 1'b0, 1'b0);
        send_instr(16'h0006, 32'h0F0F_F0F0, 1'b1, 1'b1);
        directed_items = items_sent;
    endtask

    // Mostly contiguous programs with random content, some stray instructions.
    task automatic run_random(input int count);
        int          done;
        int          run_len;
        logic [15:0] addr;
        logic        four;
        done = 0;
        while (done < count) begin
            if ($urandom_range(99) < 80) begin
                addr = ($urandom_range(9) == 0) ? 16'($urandom_range(16'hFFFF, 16'hFFF0))
                                                : 16'($urandom);
                run_len = $urandom_range(24, 1);
                for (int i = 0; i < run_len; i++) begin
                    four = 1'($urandom_range(1));
                    send_instr(addr, $urandom, four,
                               (i == run_len - 1) && ($urandom_range(2) != 0));
                    addr = addr + (four ? 16'd2 : 16'd1);
                    done++;
                end
            end else begin
                case ($urandom_range(2))
                    0: addr = last_sent_addr;
                    1: addr = last_sent_addr - 16'($urandom_range(3, 1));
                    default: addr = 16'($urandom);
                endcase
                send_instr(addr, $urandom, 1'($urandom_range(1)), $urandom_range(3) == 0);
                done++;
            end
            if (done >= count / 2 && done - count / 2 < 24 && $urandom_range(3) == 0) begin
                wait_drained();
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 9;
        recv_idle_pct = 86;
        run_directed();
        run_random(320);
        wait_drained();
        send_idle_pct = 86;
        recv_idle_pct = 9;
        run_random(330);
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(350);
        wait_drained();
        repeat (16) @(posedge aclk);
        $display("Covered %0d instructions (%0d directed) and %0d records checked,",
                 items_sent, directed_items, records_checked);
        $display("through output stalls, input gaps, full drains and free-running flow.");
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #(64'd20 * 64'd2_000_000);
        $display("Timeout: records still outstanding: %0d", pending_records);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

/* sim.f */
rtl/ihrp_pkg.sv
rtl/intel_hex_record_packer_unit.sv
rtl/ihrp_checker.sv
sim/ihex_record_checker.sv
sim/tb.sv
